### rtl/core/gnps_pkg.sv
// Shared types and constants of the gated nearest-point selector.
`default_nettype none
package gnps_pkg;

  // Gate radius registers and their squares
  localparam int RADIUS_BITS    = 16;
  localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;

  // Result coordinates are always this wide on the port
  localparam int OUT_COORD_BITS = 16;

  // Configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = RADIUS_BITS;

  localparam logic [RADIUS_BITS-1:0] DETECT_RADIUS_RST  = 16'd1000;
  localparam logic [RADIUS_BITS-1:0] TRACK_RADIUS_RST   = 16'd200;
  localparam logic [RADIUS_BITS-1:0] PREDICT_RADIUS_RST = 16'd400;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_DETECT_RADIUS  = 2'd0,
    REG_TRACK_RADIUS   = 2'd1,
    REG_PREDICT_RADIUS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_DETECT  = 2'd0,
    MODE_TRACK   = 2'd1,
    MODE_PREDICT = 2'd2
  } mode_t;

  // Per-item control flags carried down the queue
  typedef struct packed {
    logic has_point;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/core/gated_nearest_point_select.sv
// Top level of the gated nearest-point selector.
// Gated nearest-point selector. A frame is a run of candidate 3-D points, one
// item per point, ending with the item that has tlast set; every item also
// carries a mode (detection, tracking, prediction; code three acts as
// prediction) and a 2-D search point, which detection mode replaces by the
// origin. A candidate passes the gate when its squared planar distance to the
// search point is no greater than the square of the mode's radius register;
// of the passing candidates the nearest is kept, the earlier one on a tie. The
// tlast item produces exactly one result item: found in tuser and the chosen
// point in tdata (zeros when nothing passed), then the selection starts over.
// An empty frame is a single item with has_point clear and tlast set. The
// block takes one item per clock cycle while the queue has room; a result
// waiting on out_tready holds the back end and lets the queue fill. The front
// end computes the differences and picks the radius combinationally, a
// four-entry queue decouples it from the back end, and the back end squares in
// one registered stage and updates the running minimum in the next. Radius
// registers are written through cfg_we/cfg_addr/cfg_wdata and should change
// only while no frame is in flight.
`default_nettype none
module gated_nearest_point_select #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  // Configuration write port
  input  wire logic                                       cfg_we,
  input  wire logic [gnps_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
  input  wire logic [gnps_pkg::CFG_DATA_BITS-1:0]         cfg_wdata,
  // Candidate items
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // search_x, search_y, point_x, point_y, point_z, zero pad
  input  wire logic [((5*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  // mode [1:0], has_point [2]
  input  wire logic [2:0]                                 in_tuser,
  input  wire logic                                       in_tlast,
  // Result items
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // target_x, target_y, target_z
  output logic [3*gnps_pkg::OUT_COORD_BITS-1:0]           out_tdata,
  // found
  output logic [0:0]                                      out_tuser
);

  localparam int C  = COORD_BITS;
  localparam int QW = 2 * (C + 1) + gnps_pkg::RADIUS_BITS + 3 * C + $bits(gnps_pkg::ctl_t);

  logic signed [C-1:0] search_x, search_y;
  logic signed [C-1:0] point_x, point_y, point_z;
  gnps_pkg::mode_t     mode;
  gnps_pkg::ctl_t      in_ctl;

  logic signed [C:0]                   f_dx, f_dy;
  logic [gnps_pkg::RADIUS_BITS-1:0]    f_radius;

  logic [QW-1:0]                       q_wdata, q_rdata;
  logic                                q_full, q_valid, q_pop;
  logic signed [C:0]                   q_dx, q_dy;
  logic [gnps_pkg::RADIUS_BITS-1:0]    q_radius;
  logic [C-1:0]                        q_px, q_py, q_pz;
  gnps_pkg::ctl_t                      q_ctl;

  logic                                res_found;
  logic [gnps_pkg::OUT_COORD_BITS-1:0] res_x, res_y, res_z;

  // Unpack the input item
  assign search_x         = in_tdata[0*C +: C];
  assign search_y         = in_tdata[1*C +: C];
  assign point_x          = in_tdata[2*C +: C];
  assign point_y          = in_tdata[3*C +: C];
  assign point_z          = in_tdata[4*C +: C];
  assign mode             = gnps_pkg::mode_t'(in_tuser[1:0]);
  assign in_ctl.has_point = in_tuser[2];
  assign in_ctl.last      = in_tlast;

  gnps_front #(
    .COORD_BITS (C)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mode      (mode),
    .search_x  (search_x),
    .search_y  (search_y),
    .point_x   (point_x),
    .point_y   (point_y),
    .dx        (f_dx),
    .dy        (f_dy),
    .radius    (f_radius)
  );

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_wdata   = {in_ctl, point_z, point_y, point_x, f_radius, f_dy, f_dx};

  gnps_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  assign {q_ctl, q_pz, q_py, q_px, q_radius, q_dy, q_dx} = q_rdata;

  gnps_back #(
    .COORD_BITS (C)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_dx      (q_dx),
    .q_dy      (q_dy),
    .q_radius  (q_radius),
    .q_px      (q_px),
    .q_py      (q_py),
    .q_pz      (q_pz),
    .q_ctl     (q_ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_found (res_found),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_z     (res_z)
  );

  assign out_tdata    = {res_z, res_y, res_x};
  assign out_tuser[0] = res_found;

endmodule
`default_nettype wire

### rtl/core/gnps_front.sv
// Front end: radius registers, gate selection and search-point differences.
`default_nettype none
module gnps_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [gnps_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire logic [gnps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  wire gnps_pkg::mode_t                      mode,
  input  wire logic signed [COORD_BITS-1:0]         search_x,
  input  wire logic signed [COORD_BITS-1:0]         search_y,
  input  wire logic signed [COORD_BITS-1:0]         point_x,
  input  wire logic signed [COORD_BITS-1:0]         point_y,
  output logic signed [COORD_BITS:0]                dx,
  output logic signed [COORD_BITS:0]                dy,
  output logic [gnps_pkg::RADIUS_BITS-1:0]          radius
);

  logic [gnps_pkg::RADIUS_BITS-1:0] detect_r,  detect_nxt;
  logic [gnps_pkg::RADIUS_BITS-1:0] track_r,   track_nxt;
  logic [gnps_pkg::RADIUS_BITS-1:0] predict_r, predict_nxt;

  logic signed [COORD_BITS:0] sx_ext;
  logic signed [COORD_BITS:0] sy_ext;
  logic signed [COORD_BITS:0] px_ext;
  logic signed [COORD_BITS:0] py_ext;

  // Register writes
  always_comb begin
    detect_nxt  = detect_r;
    track_nxt   = track_r;
    predict_nxt = predict_r;
    if (cfg_we) begin
      case (gnps_pkg::cfg_reg_t'(cfg_addr))
        gnps_pkg::REG_DETECT_RADIUS:  detect_nxt  = cfg_wdata;
        gnps_pkg::REG_TRACK_RADIUS:   track_nxt   = cfg_wdata;
        gnps_pkg::REG_PREDICT_RADIUS: predict_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_r  <= gnps_pkg::DETECT_RADIUS_RST;
      track_r   <= gnps_pkg::TRACK_RADIUS_RST;
      predict_r <= gnps_pkg::PREDICT_RADIUS_RST;
    end else begin
      detect_r  <= detect_nxt;
      track_r   <= track_nxt;
      predict_r <= predict_nxt;
    end
  end

  // Classify by mode: detection searches around the origin
  always_comb begin
    sx_ext = {search_x[COORD_BITS-1], search_x};
    sy_ext = {search_y[COORD_BITS-1], search_y};
    case (mode)
      gnps_pkg::MODE_DETECT: begin
        sx_ext = '0;
        sy_ext = '0;
        radius = detect_r;
      end
      gnps_pkg::MODE_TRACK: radius = track_r;
      default:              radius = predict_r;
    endcase
  end

  assign px_ext = {point_x[COORD_BITS-1], point_x};
  assign py_ext = {point_y[COORD_BITS-1], point_y};
  assign dx     = sx_ext - px_ext;
  assign dy     = sy_ext - py_ext;

endmodule
`default_nettype wire

### rtl/core/gnps_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none
module gnps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    entry_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r,  count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full      = (count_r == DEPTH_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gnps_back.sv
// Back end: squaring stage, gated running minimum and result register.
`default_nettype none
module gnps_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      q_valid,
  output logic                                           q_pop,
  input  wire logic signed [COORD_BITS:0]                q_dx,
  input  wire logic signed [COORD_BITS:0]                q_dy,
  input  wire logic [gnps_pkg::RADIUS_BITS-1:0]          q_radius,
  input  wire logic [COORD_BITS-1:0]                     q_px,
  input  wire logic [COORD_BITS-1:0]                     q_py,
  input  wire logic [COORD_BITS-1:0]                     q_pz,
  input  wire gnps_pkg::ctl_t                            q_ctl,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic                                           out_found,
  output logic [gnps_pkg::OUT_COORD_BITS-1:0]            out_x,
  output logic [gnps_pkg::OUT_COORD_BITS-1:0]            out_y,
  output logic [gnps_pkg::OUT_COORD_BITS-1:0]            out_z
);

  localparam int DW  = 2 * COORD_BITS + 2;
  localparam int RSQ = gnps_pkg::RADIUS_SQ_BITS;
  localparam int CW  = (DW > RSQ) ? DW : RSQ;
  localparam int OW  = gnps_pkg::OUT_COORD_BITS;

  // Squaring stage
  logic                a_valid_r, a_valid_nxt;
  logic [DW-1:0]       a_sqx_r;
  logic [DW-1:0]       a_sqy_r;
  logic [RSQ-1:0]      a_rsq_r;
  logic [COORD_BITS-1:0] a_px_r, a_py_r, a_pz_r;
  gnps_pkg::ctl_t      a_ctl_r;

  // Running selection
  logic [RSQ-1:0]        best_d_r,   best_d_nxt;
  logic [COORD_BITS-1:0] best_x_r,   best_x_nxt;
  logic [COORD_BITS-1:0] best_y_r,   best_y_nxt;
  logic [COORD_BITS-1:0] best_z_r,   best_z_nxt;
  logic                  any_r,      any_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  found_r,     found_nxt;
  logic [OW-1:0]         tx_r, tx_nxt;
  logic [OW-1:0]         ty_r, ty_nxt;
  logic [OW-1:0]         tz_r, tz_nxt;

  logic signed [DW-1:0]  dx_w;
  logic signed [DW-1:0]  dy_w;
  logic [RSQ-1:0]        r_w;
  logic [DW-1:0]         dist_sq;
  logic                  win;
  logic                  out_free;
  logic                  b_take;
  logic                  a_load;
  logic [COORD_BITS-1:0] sel_x, sel_y, sel_z;
  logic [COORD_BITS+OW-1:0] wide_x, wide_y, wide_z;

  assign dx_w = {{(DW-COORD_BITS-1){q_dx[COORD_BITS]}}, q_dx};
  assign dy_w = {{(DW-COORD_BITS-1){q_dy[COORD_BITS]}}, q_dy};
  assign r_w  = {{(RSQ-gnps_pkg::RADIUS_BITS){1'b0}}, q_radius};

  // Hold stage A while the tail item waits for the result register
  assign out_free    = !out_valid_r || out_ready;
  assign b_take      = a_valid_r && (!a_ctl_r.last || out_free);
  assign a_load      = !a_valid_r || b_take;
  assign q_pop       = q_valid && a_load;
  assign a_valid_nxt = a_load ? q_valid : a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_sqx_r <= dx_w * dx_w;
      a_sqy_r <= dy_w * dy_w;
      a_rsq_r <= r_w * r_w;
      a_px_r  <= q_px;
      a_py_r  <= q_py;
      a_pz_r  <= q_pz;
      a_ctl_r <= q_ctl;
    end
  end

  // Gate and nearest test; strict compare keeps the earlier point on a tie
  assign dist_sq = a_sqx_r + a_sqy_r;
  assign win     = a_ctl_r.has_point
                && (CW'(dist_sq) <= CW'(a_rsq_r))
                && (CW'(dist_sq) <  CW'(best_d_r));

  always_comb begin
    sel_x  = win ? a_px_r : best_x_r;
    sel_y  = win ? a_py_r : best_y_r;
    sel_z  = win ? a_pz_r : best_z_r;
    wide_x = {{OW{1'b0}}, sel_x};
    wide_y = {{OW{1'b0}}, sel_y};
    wide_z = {{OW{1'b0}}, sel_z};
  end

  always_comb begin
    best_d_nxt    = best_d_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    best_z_nxt    = best_z_r;
    any_nxt       = any_r;
    found_nxt     = found_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    tz_nxt        = tz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (b_take) begin
      if (a_ctl_r.last) begin
        // Emit the frame result and clear the selection
        out_valid_nxt = 1'b1;
        found_nxt     = win || any_r;
        tx_nxt        = wide_x[OW-1:0];
        ty_nxt        = wide_y[OW-1:0];
        tz_nxt        = wide_z[OW-1:0];
        best_d_nxt    = '1;
        best_x_nxt    = '0;
        best_y_nxt    = '0;
        best_z_nxt    = '0;
        any_nxt       = 1'b0;
      end else if (win) begin
        best_d_nxt = dist_sq[RSQ-1:0];
        best_x_nxt = a_px_r;
        best_y_nxt = a_py_r;
        best_z_nxt = a_pz_r;
        any_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_d_r    <= '1;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_z_r    <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      best_d_r    <= best_d_nxt;
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      best_z_r    <= best_z_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    tz_r    <= tz_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = found_r;
  assign out_x     = tx_r;
  assign out_y     = ty_r;
  assign out_z     = tz_r;

endmodule
`default_nettype wire

### sim/gnps_frame_checker.sv
// Frame checker for the gated nearest-point selector: predicts each frame's target and compares.
module gnps_frame_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gnps_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [gnps_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [79:0]                        in_tdata,
  input  logic [2:0]                         in_tuser,
  input  logic                               in_tlast,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [47:0]                        out_tdata,
  input  logic [0:0]                         out_tuser,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic        found;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } target_t;

  target_t expected_targets[$];

  logic [15:0] detect_r;
  logic [15:0] track_r;
  logic [15:0] predict_r;

  // running selection of the frame in progress
  u64_t        best_dist;
  logic [15:0] best_x;
  logic [15:0] best_y;
  logic [15:0] best_z;
  logic        any_hit;

  int          errors = 0;
  int          queued = 0;

  logic [1:0]         item_mode;
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  u64_t               dist_sq;
  u64_t               lim;
  target_t            want;
  target_t            got;

  assign fail_count = errors;
  assign pending    = queued;

  function automatic u64_t planar_dist_sq(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return u64_t'(dx * dx) + u64_t'(dy * dy);
  endfunction

  // code three falls through to the prediction radius
  function automatic logic [15:0] gate_radius(logic [1:0] m);
    if (m == gnps_pkg::MODE_DETECT) return detect_r;
    if (m == gnps_pkg::MODE_TRACK) return track_r;
    return predict_r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      detect_r  = gnps_pkg::DETECT_RADIUS_RST;
      track_r   = gnps_pkg::TRACK_RADIUS_RST;
      predict_r = gnps_pkg::PREDICT_RADIUS_RST;
      best_dist = '1;
      best_x    = '0;
      best_y    = '0;
      best_z    = '0;
      any_hit   = 1'b0;
      expected_targets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          gnps_pkg::REG_DETECT_RADIUS:  detect_r  = cfg_wdata;
          gnps_pkg::REG_TRACK_RADIUS:   track_r   = cfg_wdata;
          gnps_pkg::REG_PREDICT_RADIUS: predict_r = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        item_mode = in_tuser[1:0];
        if (in_tuser[2]) begin
          if (item_mode == gnps_pkg::MODE_DETECT) begin
            sx = '0;
            sy = '0;
          end else begin
            sx = in_tdata[15:0];
            sy = in_tdata[31:16];
          end
          dist_sq = planar_dist_sq(sx, sy, in_tdata[47:32], in_tdata[63:48]);
          lim     = u64_t'(gate_radius(item_mode)) * u64_t'(gate_radius(item_mode));
          if (dist_sq <= lim && dist_sq < best_dist) begin
            best_dist = dist_sq;
            best_x    = in_tdata[47:32];
            best_y    = in_tdata[63:48];
            best_z    = in_tdata[79:64];
            any_hit   = 1'b1;
          end
        end
        if (in_tlast) begin
          want.found = any_hit;
          want.x     = any_hit ? best_x : '0;
          want.y     = any_hit ? best_y : '0;
          want.z     = any_hit ? best_z : '0;
          expected_targets = {expected_targets, want};
          best_dist = '1;
          best_x    = '0;
          best_y    = '0;
          best_z    = '0;
          any_hit   = 1'b0;
        end
      end

      if (out_tvalid && out_tready) begin
        got.found = out_tuser[0];
        got.x     = out_tdata[15:0];
        got.y     = out_tdata[31:16];
        got.z     = out_tdata[47:32];
        if (expected_targets.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b x=%h y=%h z=%h",
                                    got.found, got.x, got.y, got.z));
        end else begin
          want = expected_targets.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
          if (got.x !== want.x)
            report_mismatch($sformatf("target_x %h, want %h", got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("target_y %h, want %h", got.y, want.y));
          if (got.z !== want.z)
            report_mismatch($sformatf("target_z %h, want %h", got.z, want.z));
        end
      end
    end
    queued <= expected_targets.size();
  end

endmodule

### sim/gated_nearest_point_select_test.sv
// Testbench top for the gated nearest-point selector: stimulus, reset and verdict.
module gated_nearest_point_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASE_ITEMS  = 180;
  localparam int IDLE_PCT     = 29;
  // code three carries no enum member; it acts as prediction
  localparam logic [1:0] MODE_ALIAS_PREDICT = 2'd3;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [gnps_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [gnps_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [79:0]                        in_tdata;   // search_x, search_y, point_x, point_y, point_z
  logic [2:0]                         in_tuser;   // mode [1:0], has_point [2]
  logic                               in_tlast;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [47:0]                        out_tdata;  // target_x, target_y, target_z
  logic [0:0]                         out_tuser;  // found

  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          items_sent = 0;
  logic        idle_on;
  // radii as last written, used to aim candidates near the gate
  logic [15:0] gate_r [3];

  always #5 clk = ~clk;

  gated_nearest_point_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gnps_frame_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result side at random while idling is on; hold ready high otherwise.
  always @(posedge clk) begin
    out_tready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item, with an optional gap before it, and hold it until taken.
  // Valid stays high between back-to-back items, so it is never lowered and
  // raised in the same step.
  task automatic send_item(logic [1:0] mode, logic [15:0] sx, logic [15:0] sy,
                           logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                           logic has, logic last);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px, sy, sx};
    in_tuser  <= {has, mode};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Drop valid and wait for every predicted result, then let the pipe empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all three radius registers back to back; call only when drained.
  task automatic set_radii(logic [15:0] d, logic [15:0] t, logic [15:0] p);
    cfg_we    <= 1'b1;
    cfg_addr  <= gnps_pkg::REG_DETECT_RADIUS;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_addr  <= gnps_pkg::REG_TRACK_RADIUS;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_addr  <= gnps_pkg::REG_PREDICT_RADIUS;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gate_r[0] = d;
    gate_r[1] = t;
    gate_r[2] = p;
  endtask

  // Favor the extremes and small gates, with some fully random values.
  function automatic logic [15:0] pick_radius();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 50));
      5:       return 16'($urandom);
      default: return 16'($urandom_range(50, 3000));
    endcase
  endfunction

  // Send one frame. Most candidates land around the gate of their mode so
  // that both sides of the radius and the running minimum get exercised;
  // the rest are wild points, swapped-offset ties and empty items.
  task automatic send_random_frame();
    int          len;
    int          span;
    int          cx;
    int          cy;
    int          dx;
    int          dy;
    int          prev_dx;
    int          prev_dy;
    int          pick;
    logic [1:0]  mode;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] px;
    logic [15:0] py;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    mode = $urandom_range(0, 3);
    sx   = $urandom;
    sy   = $urandom;
    prev_dx = 0;
    prev_dy = 0;
    for (int i = 0; i < len; i++) begin
      // mixed modes or a moved search point inside a frame now and then
      if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) begin
        sx = $urandom;
        sy = $urandom;
      end
      span = int'(gate_r[(mode == MODE_ALIAS_PREDICT) ? 2 : mode]);
      span = span + span / 2 + 2;
      cx   = (mode == gnps_pkg::MODE_DETECT) ? 0 : int'($signed(sx));
      cy   = (mode == gnps_pkg::MODE_DETECT) ? 0 : int'($signed(sy));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        dx = int'($signed(16'($urandom))) - cx;
        dy = int'($signed(16'($urandom))) - cy;
      end else if (pick < 22 && i > 0) begin
        // equal distance to the previous candidate
        dx = prev_dy;
        dy = prev_dx;
      end else begin
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
      end
      prev_dx = dx;
      prev_dy = dy;
      px = 16'(cx + dx);
      py = 16'(cy + dy);
      send_item(mode, sx, sy, px, py, 16'($urandom), $urandom_range(0, 9) != 0, i == len - 1);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = gnps_pkg::REG_DETECT_RADIUS;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    idle_on    = 1'b1;
    gate_r[0]  = gnps_pkg::DETECT_RADIUS_RST;
    gate_r[1]  = gnps_pkg::TRACK_RADIUS_RST;
    gate_r[2]  = gnps_pkg::PREDICT_RADIUS_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset radii 1000 / 200 / 400.
    // empty frame
    send_item(gnps_pkg::MODE_DETECT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    // detection ignores the search point; a point right on the gate passes
    send_item(gnps_pkg::MODE_DETECT, 16'sd12345, -16'sd777, 16'sd600, 16'sd800, -16'sd5,
              1'b1, 1'b1);
    // just outside the gate
    send_item(gnps_pkg::MODE_DETECT, 16'sd12345, -16'sd777, 16'sd601, 16'sd800, 16'sd9,
              1'b1, 1'b1);
    // tracking at the negative corner: on the gate, then a tie, then an empty last
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, -16'sd32648, -16'sd32608, 16'sd1,
              1'b1, 1'b0);
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, -16'sd32608, -16'sd32648, 16'sd2,
              1'b1, 1'b0);
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    // prediction at the positive corner: gate edge, then an exact hit wins
    send_item(gnps_pkg::MODE_PREDICT, 16'sd32767, 16'sd32767, 16'sd32367, 16'sd32767,
              16'sd32767, 1'b1, 1'b0);
    send_item(gnps_pkg::MODE_PREDICT, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
              16'h8000, 1'b1, 1'b1);
    // code three uses the prediction radius
    send_item(MODE_ALIAS_PREDICT, 16'sd100, -16'sd100, 16'sd100, 16'sd300, 16'sd7, 1'b1, 1'b1);
    send_item(MODE_ALIAS_PREDICT, 16'sd100, -16'sd100, 16'sd100, -16'sd501, 16'sd7, 1'b1, 1'b1);
    // mixed modes in one frame: the nearer tracking point replaces the detection one
    send_item(gnps_pkg::MODE_DETECT, 16'sd5000, 16'sd5000, 16'sd100, 16'sd0, 16'sd3,
              1'b1, 1'b0);
    send_item(gnps_pkg::MODE_TRACK, 16'sd5000, 16'sd5000, 16'sd5000, 16'sd5050, 16'sd4,
              1'b1, 1'b1);
    // opposite corners, far outside
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, 16'sd32767, 16'sd32767, 16'sd5,
              1'b1, 1'b1);

    // widest gates: a full-span offset on one axis passes, on two it does not
    drain();
    set_radii(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, 16'sd32767, 16'h8000, 16'sd11,
              1'b1, 1'b0);
    send_item(gnps_pkg::MODE_TRACK, 16'h8000, 16'h8000, 16'sd32767, 16'sd32767, 16'sd12,
              1'b1, 1'b1);

    // zero gates: only an exact hit passes
    drain();
    set_radii(16'd0, 16'd0, 16'd0);
    send_item(gnps_pkg::MODE_DETECT, 16'sd40, 16'sd40, 16'sd0, 16'sd0, -16'sd1, 1'b1, 1'b1);
    send_item(gnps_pkg::MODE_TRACK, -16'sd5, 16'sd7, -16'sd5, 16'sd8, 16'sd2, 1'b1, 1'b1);
    send_item(gnps_pkg::MODE_PREDICT, -16'sd5, 16'sd7, -16'sd5, 16'sd7, 16'sd3, 1'b1, 1'b1);
    send_item(gnps_pkg::MODE_DETECT, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd4, 1'b1, 1'b1);

    // Random part: one radius setting per phase, one phase without idling.
    items_sent = 0;
    for (int phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      drain();
      if (phase == 0)
        set_radii(16'hFFFF, 16'd0, 16'd1);
      else
        set_radii(pick_radius(), pick_radius(), pick_radius());
      idle_on = (phase != 2);
      while (items_sent < (phase + 1) * PHASE_ITEMS && items_sent < RANDOM_ITEMS)
        send_random_frame();
    end

    drain();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/core/gnps_pkg.sv
rtl/core/gnps_front.sv
rtl/core/gnps_queue.sv
rtl/core/gnps_back.sv
rtl/core/gated_nearest_point_select.sv
sim/gnps_frame_checker.sv
sim/gated_nearest_point_select_test.sv
